@@ rtl/ipu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ipu_pkg;

   // Field and register widths.
   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int SCALE_W     = 7;
   localparam int ROW_WIDTH_W = 13;
   localparam int REPEAT_W    = 6;
   localparam int PAD_W       = 2;

   // Largest enlargement factor; larger register values saturate to it.
   localparam logic [SCALE_W-1:0] SCALE_LIMIT = 7'd64;

   // Default line store depth.
   localparam int DEFAULT_MAX_ROW_WIDTH = 4096;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = ROW_WIDTH_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH = 2'd1;

   // One classified item as it travels from front to back.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;     // {red, green, blue}
      logic               consumed;
      logic               row_end;
      logic [PAD_W-1:0]   pad;
      logic [SCALE_W-1:0] copies;
   } desc_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ rtl/integer_pixel_upscaler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor integer upscaler for 24-bit pixels. Every accepted item
// produces scale result items (1 to 64), sent one per cycle from the single
// output register while rsp_ready is high; the next item is loaded as the last
// copy of the current one leaves. While a row is being replayed the offered
// pixel is accepted but ignored and the copy comes from the line store. An
// accepted item passes the line store read, the queue and the output register
// before its first copy. The line store needs no clearing pass after reset.
// Write scale and row_width only while no results are outstanding.
module integer_pixel_upscaler_top #(
   parameter int MAX_ROW_WIDTH = ipu_pkg::DEFAULT_MAX_ROW_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [ipu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ipu_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ipu_pkg::COLOR_W-1:0]       req_in_blue,
   input  wire logic [ipu_pkg::COLOR_W-1:0]       req_in_green,
   input  wire logic [ipu_pkg::COLOR_W-1:0]       req_in_red,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ipu_pkg::COLOR_W-1:0]            rsp_out_blue,
   output logic [ipu_pkg::COLOR_W-1:0]            rsp_out_green,
   output logic [ipu_pkg::COLOR_W-1:0]            rsp_out_red,
   output logic                                   rsp_last_copy,
   output logic                                   rsp_row_end,
   output logic [ipu_pkg::PAD_W-1:0]              rsp_pad_bytes,
   output logic                                   rsp_pixel_consumed
);

   import ipu_pkg::*;

   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic                   push;
   desc_type               push_desc;
   logic                   pop;
   desc_type               pop_desc;
   queue_status_type       queue_status;
   logic [PIXEL_W-1:0]     rsp_pixel;

   // Configuration registers; unknown indexes are ignored.
   always_comb begin
      scale_in     = scale_ff;
      row_width_in = row_width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCALE:     scale_in     = csr_wdata[SCALE_W-1:0];
            CSR_ROW_WIDTH: row_width_in = csr_wdata[ROW_WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_W'(1);
         row_width_ff <= ROW_WIDTH_W'(1);
      end else begin
         scale_ff     <= scale_in;
         row_width_ff <= row_width_in;
      end
   end

   // Front: accepts, tracks the row position and writes and reads the line store.
   ipu_front #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .scale        (scale_ff),
      .row_width    (row_width_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    ({req_in_red, req_in_green, req_in_blue}),
      .queue_status (queue_status),
      .push         (push),
      .push_desc    (push_desc)
   );

   ipu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .status    (queue_status)
   );

   // Back: sends the copies of each item.
   ipu_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_status       (queue_status),
      .pop_desc           (pop_desc),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel          (rsp_pixel),
      .rsp_last_copy      (rsp_last_copy),
      .rsp_row_end        (rsp_row_end),
      .rsp_pad_bytes      (rsp_pad_bytes),
      .rsp_pixel_consumed (rsp_pixel_consumed)
   );

   assign rsp_out_blue  = rsp_pixel[COLOR_W-1:0];
   assign rsp_out_green = rsp_pixel[2*COLOR_W-1:COLOR_W];
   assign rsp_out_red   = rsp_pixel[3*COLOR_W-1:2*COLOR_W];

endmodule

`default_nettype wire

@@ rtl/ipu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              write_en,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic              read_en,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

@@ rtl/ipu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipu_front #(
   parameter int MAX_ROW_WIDTH = ipu_pkg::DEFAULT_MAX_ROW_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [ipu_pkg::SCALE_W-1:0]         scale,
   input  wire logic [ipu_pkg::ROW_WIDTH_W-1:0]     row_width,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [ipu_pkg::PIXEL_W-1:0]         req_pixel,
   input  wire ipu_pkg::queue_status_type           queue_status,
   output logic                                     push,
   output ipu_pkg::desc_type                        push_desc
);

   import ipu_pkg::*;

   localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
   localparam int EW    = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CMP_W = (EW > ROW_WIDTH_W) ? EW : ROW_WIDTH_W;

   logic [COL_W-1:0]    column_ff, column_in;
   logic [REPEAT_W-1:0] repeat_ff, repeat_in;
   logic                replaying_ff, replaying_in;
   logic                s1_valid_ff, s1_valid_in;
   desc_type            s1_desc_ff, s1_desc_in;

   logic                accept;
   logic [SCALE_W-1:0]  scale_eff;
   logic [EW-1:0]       width_eff;
   logic [COL_W-1:0]    col_eff;
   logic                at_row_end;
   logic [PAD_W-1:0]    bytes_mod;
   logic [PAD_W-1:0]    pad;
   logic [PIXEL_W-1:0]  ram_rdata;
   logic [QUEUE_CNT_W:0] committed;

   // Room is reserved in the queue for the item in the read stage.
   assign committed = {1'b0, queue_status.count} + {{QUEUE_CNT_W{1'b0}}, s1_valid_ff};
   assign req_ready = committed < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Saturate the configuration into its legal range.
   always_comb begin
      logic [CMP_W-1:0] rw_ext;
      logic [CMP_W-1:0] max_ext;
      rw_ext  = CMP_W'(row_width);
      max_ext = CMP_W'(MAX_ROW_WIDTH);
      if (scale == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (scale > SCALE_LIMIT) begin
         scale_eff = SCALE_LIMIT;
      end else begin
         scale_eff = scale;
      end
      if (rw_ext == '0) begin
         width_eff = EW'(1);
      end else if (rw_ext > max_ext) begin
         width_eff = EW'(max_ext);
      end else begin
         width_eff = EW'(rw_ext);
      end
   end

   // Column clamp, row end detection and pad count.
   always_comb begin
      if (EW'(column_ff) >= width_eff) begin
         col_eff = COL_W'(width_eff - EW'(1));
      end else begin
         col_eff = column_ff;
      end
      at_row_end = (EW'(col_eff) + EW'(1)) >= width_eff;
      bytes_mod  = PAD_W'(PAD_W'(width_eff) * PAD_W'(scale_eff) * PAD_W'(3));
      pad        = PAD_W'(0) - bytes_mod;
   end

   // Row position and replay phase advance on every accepted item.
   always_comb begin
      column_in    = column_ff;
      repeat_in    = repeat_ff;
      replaying_in = replaying_ff;
      if (accept) begin
         if (at_row_end) begin
            column_in = '0;
            if ({1'b0, repeat_ff} + SCALE_W'(1) < scale_eff) begin
               repeat_in    = repeat_ff + REPEAT_W'(1);
               replaying_in = 1'b1;
            end else begin
               repeat_in    = '0;
               replaying_in = 1'b0;
            end
         end else begin
            column_in = col_eff + COL_W'(1);
         end
      end
   end

   // Read stage registers the item alongside the line store read.
   always_comb begin
      s1_valid_in        = accept;
      s1_desc_in         = s1_desc_ff;
      if (accept) begin
         s1_desc_in.pixel    = req_pixel;
         s1_desc_in.consumed = !replaying_ff;
         s1_desc_in.row_end  = at_row_end;
         s1_desc_in.pad      = pad;
         s1_desc_in.copies   = scale_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         repeat_ff    <= '0;
         replaying_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         column_ff    <= column_in;
         repeat_ff    <= repeat_in;
         replaying_ff <= replaying_in;
         s1_valid_ff  <= s1_valid_in;
      end
      s1_desc_ff <= s1_desc_in;
   end

   // Captured pixels are written, replayed pixels are read back.
   ipu_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_ROW_WIDTH)
   ) u_line_store (
      .clock      (clock),
      .write_en   (accept && !replaying_ff),
      .write_addr (col_eff),
      .write_data (req_pixel),
      .read_en    (accept && replaying_ff),
      .read_addr  (col_eff),
      .read_data  (ram_rdata)
   );

   // Hand the classified item to the queue.
   always_comb begin
      push      = s1_valid_ff;
      push_desc = s1_desc_ff;
      if (!s1_desc_ff.consumed) begin
         push_desc.pixel = ram_rdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ipu_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ipu_pkg::desc_type push_desc,
   input  wire logic              pop,
   output ipu_pkg::desc_type      pop_desc,
   output ipu_pkg::queue_status_type status
);

   import ipu_pkg::*;

   desc_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   // Pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign pop_desc     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ rtl/ipu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipu_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ipu_pkg::queue_status_type       queue_status,
   input  wire ipu_pkg::desc_type               pop_desc,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [ipu_pkg::PIXEL_W-1:0]          rsp_pixel,
   output logic                                 rsp_last_copy,
   output logic                                 rsp_row_end,
   output logic [ipu_pkg::PAD_W-1:0]            rsp_pad_bytes,
   output logic                                 rsp_pixel_consumed
);

   import ipu_pkg::*;

   logic               valid_ff, valid_in;
   desc_type           desc_ff, desc_in;
   logic [SCALE_W-1:0] remain_ff, remain_in;
   logic               last;
   logic               fire;

   assign last = (remain_ff == SCALE_W'(1));
   assign fire = valid_ff && rsp_ready;

   // Take the next item once the last copy of the current one leaves.
   assign pop = !queue_status.empty && (!valid_ff || (fire && last));

   always_comb begin
      valid_in  = valid_ff;
      desc_in   = desc_ff;
      remain_in = remain_ff;
      if (pop) begin
         valid_in  = 1'b1;
         desc_in   = pop_desc;
         remain_in = pop_desc.copies;
      end else if (fire) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            remain_in = remain_ff - SCALE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
      desc_ff <= desc_in;
   end

   // Row end and padding only ride on the final copy.
   assign rsp_valid          = valid_ff;
   assign rsp_pixel          = desc_ff.pixel;
   assign rsp_last_copy      = last;
   assign rsp_row_end        = last && desc_ff.row_end;
   assign rsp_pad_bytes      = (last && desc_ff.row_end) ? desc_ff.pad : '0;
   assign rsp_pixel_consumed = desc_ff.consumed;

endmodule

`default_nettype wire

@@ rtl/ipu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ipu_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [ipu_pkg::COLOR_W-1:0]       rsp_out_blue,
   input wire logic [ipu_pkg::COLOR_W-1:0]       rsp_out_green,
   input wire logic [ipu_pkg::COLOR_W-1:0]       rsp_out_red,
   input wire logic                              rsp_last_copy,
   input wire logic                              rsp_row_end,
   input wire logic [ipu_pkg::PAD_W-1:0]         rsp_pad_bytes,
   input wire logic                              rsp_pixel_consumed
);

   // A stalled result keeps its pixel and its last copy and row end flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_last_copy) && $stable(rsp_row_end))
      else $error("stalled result changed");

   // Row end is only flagged on the final copy of an item.
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_last_copy)
      else $error("row end on a copy that is not the last");

   // Padding appears only at the end of an output row.
   a_pad_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_end |-> rsp_pad_bytes == '0)
      else $error("pad bytes outside a row end");

   // The copies of one item follow without a gap and repeat its pixel.
   a_copy_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_copy |=> rsp_valid
         && $stable(rsp_out_red) && $stable(rsp_out_green)
         && $stable(rsp_out_blue) && $stable(rsp_pixel_consumed))
      else $error("copy run broken or pixel changed");

endmodule

bind integer_pixel_upscaler_top ipu_checker u_checker (.*);

`default_nettype wire
